/* hdl/quaternion_to_euler_angles_unit_assert.svh */
// Assertion macros for the quaternion to Euler angle unit.
// Each macro expects clk_i and rst_ni in the scope of the use.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg)
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/q2e_pkg.sv */
package q2e_pkg;

  localparam int unsigned DataWidthDef    = 16;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned ProdWidth       = 32;  // Q2.30 products
  localparam int unsigned VecWidth        = 36;  // CORDIC vector components
  localparam int unsigned SqrtBits        = 31;  // root bits of a 61-bit radicand
  localparam int unsigned RemWidth        = 61;
  localparam logic [15:0] TolReset        = 16'd1;

  typedef enum logic [1:0] {
    GC_NORMAL = 2'd0,
    GC_POS    = 2'd1,
    GC_NEG    = 2'd2
  } gimbal_e;

  typedef struct packed {
    logic signed [VecWidth-1:0] x;
    logic signed [VecWidth-1:0] y;
    logic [31:0]                z;
  } vec_t;

  typedef struct packed {
    logic    sat_pos;
    logic    sat_neg;
    logic    roll_zero;
    logic    yaw_zero;
    gimbal_e gcase;
  } flags_t;

  // item in the square root chain
  typedef struct packed {
    logic [RemWidth-1:0]        rem;
    logic [SqrtBits-1:0]        root;
    logic signed [VecWidth-1:0] s;
    vec_t                       roll;
    vec_t                       yaw;
    flags_t                     flags;
  } sq_item_t;

  // item in the CORDIC chain
  typedef struct packed {
    vec_t   roll;
    vec_t   yaw;
    vec_t   pitch;
    flags_t flags;
  } cr_item_t;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // turn a vector into the right half plane
  function automatic vec_t cordic_prerot(vec_t v);
    vec_t r;
    r = v;
    r.z = 32'h0000_0000;
    if (v.x[VecWidth-1]) begin
      if (!v.y[VecWidth-1]) begin
        r.x = v.y;
        r.y = -v.x;
        r.z = 32'h4000_0000;
      end else begin
        r.x = -v.y;
        r.y = v.x;
        r.z = 32'hC000_0000;
      end
    end
    return r;
  endfunction

  // one vectoring micro-rotation
  function automatic vec_t cordic_step(vec_t v, int unsigned sh, logic [31:0] ang);
    vec_t r;
    logic signed [VecWidth-1:0] dx;
    logic signed [VecWidth-1:0] dy;
    dx = v.y >>> sh;
    dy = v.x >>> sh;
    if (!v.y[VecWidth-1]) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + ang;
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - ang;
    end
    return r;
  endfunction

  // round a 32-bit angle to a 16-bit binary angle
  function automatic logic [15:0] round_angle(logic [31:0] z);
    logic [31:0] t;
    t = z + 32'h0000_8000;
    return t[31:16];
  endfunction

endpackage

/* hdl/quaternion_to_euler_angles_unit.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid_i / in_ready_o   | quat_w_i, quat_x_i, quat_y_i, quat_z_i
// output   | out_valid_o / out_ready_i | roll_angle_o, pitch_angle_o, yaw_angle_o,
//          |                           | gimbal_case_o
// config   | cfg_we_i                  | cfg_wdata_i (gimbal tolerance)
//
// One request per cycle unless the output stalls; a request passes the product/sum front end,
// the 31 cells of the square root chain, the CORDIC cells and the output register.
// Every stage holds its request while the next one is full, so bubbles close up
// and input is taken as long as some stage is free.
// Reset clears all valid bits and sets the tolerance to 1; no clearing pass.
module quaternion_to_euler_angles_unit #(
  parameter int unsigned DATA_WIDTH    = q2e_pkg::DataWidthDef,
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CordicStagesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] quat_w_i,
  input  logic signed [DATA_WIDTH-1:0] quat_x_i,
  input  logic signed [DATA_WIDTH-1:0] quat_y_i,
  input  logic signed [DATA_WIDTH-1:0] quat_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           roll_angle_o,
  output logic signed [15:0]           pitch_angle_o,
  output logic signed [15:0]           yaw_angle_o,
  output logic [1:0]                   gimbal_case_o
);
  import q2e_pkg::*;

  `include "quaternion_to_euler_angles_unit_assert.svh"

  // tolerance register
  logic [15:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // front end
  logic     sq_v   [SqrtBits+1];
  logic     sq_r   [SqrtBits+1];
  sq_item_t sq_d   [SqrtBits+1];

  q2e_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tol_i   (tol_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .quat_w_i(quat_w_i),
    .quat_x_i(quat_x_i),
    .quat_y_i(quat_y_i),
    .quat_z_i(quat_z_i),
    .valid_o (sq_v[0]),
    .ready_i (sq_r[0]),
    .data_o  (sq_d[0])
  );

  // square root chain, most significant root bit first
  for (genvar k = 0; k < SqrtBits; k++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT(SqrtBits - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_v[k]),
      .ready_o(sq_r[k]),
      .data_i (sq_d[k]),
      .valid_o(sq_v[k+1]),
      .ready_i(sq_r[k+1]),
      .data_o (sq_d[k+1])
    );
  end

  // hand over to the CORDIC chain with all vectors in the right half plane
  logic     cr_v [CORDIC_STAGES+1];
  logic     cr_r [CORDIC_STAGES+1];
  cr_item_t cr_d [CORDIC_STAGES+1];
  vec_t     pv;

  always_comb begin
    pv.y          = sq_d[SqrtBits].s;
    pv.x          = VecWidth'({1'b0, sq_d[SqrtBits].root});
    pv.z          = '0;
    cr_d[0].roll  = cordic_prerot(sq_d[SqrtBits].roll);
    cr_d[0].yaw   = cordic_prerot(sq_d[SqrtBits].yaw);
    cr_d[0].pitch = cordic_prerot(pv);
    cr_d[0].flags = sq_d[SqrtBits].flags;
  end

  assign cr_v[0]        = sq_v[SqrtBits];
  assign sq_r[SqrtBits] = cr_r[0];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    q2e_cordic_cell #(
      .STAGE(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cr_v[k]),
      .ready_o(cr_r[k]),
      .data_i (cr_d[k]),
      .valid_o(cr_v[k+1]),
      .ready_i(cr_r[k+1]),
      .data_o (cr_d[k+1])
    );
  end

  // output register: rounding, pitch limits, gimbal overrides
  cr_item_t           last;
  logic signed [15:0] roll_d, pitch_d, yaw_d, pr;
  logic               out_en;

  assign last   = cr_d[CORDIC_STAGES];
  assign out_en = !out_valid_o || out_ready_i;
  assign cr_r[CORDIC_STAGES] = out_en;

  always_comb begin
    roll_d = last.flags.roll_zero ? 16'sd0 : signed'(round_angle(last.roll.z));
    yaw_d  = (last.flags.yaw_zero || last.flags.gcase != GC_NORMAL)
             ? 16'sd0 : signed'(round_angle(last.yaw.z));
    pr     = signed'(round_angle(last.pitch.z));
    if (last.flags.sat_pos) pitch_d = 16'sd16384;
    else if (last.flags.sat_neg) pitch_d = -16'sd16384;
    else if (pr > 16'sd16384) pitch_d = 16'sd16384;
    else if (pr < -16'sd16384) pitch_d = -16'sd16384;
    else pitch_d = pr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_en) begin
      out_valid_o <= cr_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && cr_v[CORDIC_STAGES]) begin
      roll_angle_o  <= roll_d;
      pitch_angle_o <= pitch_d;
      yaw_angle_o   <= yaw_d;
      gimbal_case_o <= last.flags.gcase;
    end
  end

  // checks
  `Q2E_ASSERT_IMP(a_yaw_lock, out_valid_o && gimbal_case_o != GC_NORMAL, yaw_angle_o == 16'sd0, "yaw not zero in gimbal lock")
  `Q2E_ASSERT_IMP(a_pitch_rng, out_valid_o, pitch_angle_o <= 16'sd16384 && pitch_angle_o >= -16'sd16384, "pitch out of range")
  `Q2E_ASSERT_IMP(a_gcase, out_valid_o, gimbal_case_o != 2'd3, "bad gimbal case")
  `Q2E_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

endmodule

/* hdl/q2e_front.sv */
module q2e_front #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [15:0]            tol_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [DATA_WIDTH-1:0] quat_w_i,
  input  logic signed [DATA_WIDTH-1:0] quat_x_i,
  input  logic signed [DATA_WIDTH-1:0] quat_y_i,
  input  logic signed [DATA_WIDTH-1:0] quat_z_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output q2e_pkg::sq_item_t      data_o
);
  import q2e_pkg::*;

  localparam int ProdShift = 2 * (int'(DATA_WIDTH) - 1) - 30;
  localparam int unsigned ShR = (ProdShift > 0) ? ProdShift : 0;
  localparam int unsigned ShL = (ProdShift < 0) ? -ProdShift : 0;
  localparam int unsigned VW = VecWidth;

  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [VW-1:0]        wide_t;

  // rescale a product of two components to Q2.30
  function automatic prod_t mulq(logic signed [DATA_WIDTH-1:0] a,
                                 logic signed [DATA_WIDTH-1:0] b);
    logic signed [2*DATA_WIDTH-1:0] p;
    logic signed [63:0]             p64;
    p   = a * b;
    p64 = 64'(p);
    return ProdWidth'((p64 >>> ShR) <<< ShL);
  endfunction

  logic [3:0] v_q;
  logic [3:0] en;

  // stall chain: a stage moves when it is empty or its successor moves
  assign en[3] = !v_q[3] || ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // stage 0: products
  prod_t ww_q, xx_q, yy_q, zz_q, wy_q, xz_q, xy_q, wz_q, yz_q, wx_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ww_q <= mulq(quat_w_i, quat_w_i);
      xx_q <= mulq(quat_x_i, quat_x_i);
      yy_q <= mulq(quat_y_i, quat_y_i);
      zz_q <= mulq(quat_z_i, quat_z_i);
      wy_q <= mulq(quat_w_i, quat_y_i);
      xz_q <= mulq(quat_x_i, quat_z_i);
      xy_q <= mulq(quat_x_i, quat_y_i);
      wz_q <= mulq(quat_z_i, quat_w_i);
      yz_q <= mulq(quat_y_i, quat_z_i);
      wx_q <= mulq(quat_w_i, quat_x_i);
    end
  end

  // stage 1: sums
  wide_t s1_q, rn_y_q, rn_x_q, rg_y_q, rg_x_q, yw_y_q, yw_x_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q   <= (VW'(wy_q) - VW'(xz_q)) <<< 1;
      rn_y_q <= (VW'(yz_q) + VW'(wx_q)) <<< 1;
      rn_x_q <= VW'(ww_q) - VW'(xx_q) - VW'(yy_q) + VW'(zz_q);
      rg_y_q <= (VW'(xy_q) - VW'(wz_q)) <<< 1;
      rg_x_q <= VW'(ww_q) - VW'(xx_q) + VW'(yy_q) - VW'(zz_q);
      yw_y_q <= (VW'(xy_q) + VW'(wz_q)) <<< 1;
      yw_x_q <= VW'(ww_q) + VW'(xx_q) - VW'(yy_q) - VW'(zz_q);
    end
  end

  // stage 2: limits, gimbal test, roll selection, square of pitch sine
  localparam wide_t QOne = wide_t'(64'sd1 <<< 30);

  wide_t            dp, dm;
  logic             sat_p, sat_n, g_p, g_m;
  logic signed [31:0] s_clip;
  logic signed [63:0] s_sq;

  always_comb begin
    sat_p  = (s1_q >= QOne);
    sat_n  = (s1_q <= -QOne);
    dp     = s1_q - QOne;
    if (dp[VW-1]) dp = -dp;
    dm     = s1_q + QOne;
    if (dm[VW-1]) dm = -dm;
    g_p    = (dp < VW'(tol_i));
    g_m    = (dm < VW'(tol_i));
    if (sat_p) s_clip = 32'sd1073741824;
    else if (sat_n) s_clip = -32'sd1073741824;
    else s_clip = 32'(s1_q);
    s_sq   = s_clip * s_clip;
  end

  wide_t            s2_q, r_y_q, r_x_q, y_y_q, y_x_q;
  logic [RemWidth-1:0] sq_q;
  logic             sat_p_q, sat_n_q;
  gimbal_e          gc_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_q    <= s1_q;
      sat_p_q <= sat_p;
      sat_n_q <= sat_n;
      sq_q    <= RemWidth'(s_sq);
      y_y_q   <= yw_y_q;
      y_x_q   <= yw_x_q;
      if (g_p) begin
        gc_q  <= GC_POS;
        r_y_q <= rg_y_q;
        r_x_q <= rg_x_q;
      end else if (g_m) begin
        gc_q  <= GC_NEG;
        r_y_q <= -rg_y_q;
        r_x_q <= rg_x_q;
      end else begin
        gc_q  <= GC_NORMAL;
        r_y_q <= rn_y_q;
        r_x_q <= rn_x_q;
      end
    end
  end

  // stage 3: radicand and zero-vector flags
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      data_o.rem             <= (RemWidth'(1) << 60) - sq_q;
      data_o.root            <= '0;
      data_o.s               <= s2_q;
      data_o.roll.x          <= r_x_q;
      data_o.roll.y          <= r_y_q;
      data_o.roll.z          <= '0;
      data_o.yaw.x           <= y_x_q;
      data_o.yaw.y           <= y_y_q;
      data_o.yaw.z           <= '0;
      data_o.flags.sat_pos   <= sat_p_q;
      data_o.flags.sat_neg   <= sat_n_q;
      data_o.flags.roll_zero <= (r_x_q == '0) && (r_y_q == '0);
      data_o.flags.yaw_zero  <= (y_x_q == '0) && (y_y_q == '0);
      data_o.flags.gcase     <= gc_q;
    end
  end

endmodule

/* hdl/q2e_sqrt_cell.sv */
module q2e_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  q2e_pkg::sq_item_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output q2e_pkg::sq_item_t data_o
);
  import q2e_pkg::*;

  logic              v_q;
  sq_item_t          d_d;
  logic [RemWidth:0] trial;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  // try one root bit: (2*root + 2^bit) * 2^bit against the remainder
  always_comb begin
    d_d   = data_i;
    trial = ((RemWidth+1)'(data_i.root) << (BIT + 1)) + ((RemWidth+1)'(1) << (2 * BIT));
    if ({1'b0, data_i.rem} >= trial) begin
      d_d.rem       = RemWidth'({1'b0, data_i.rem} - trial);
      d_d.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_o <= d_d;
    end
  end

endmodule

/* hdl/q2e_cordic_cell.sv */
module q2e_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  q2e_pkg::cr_item_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output q2e_pkg::cr_item_t data_o
);
  import q2e_pkg::*;

  logic        v_q;
  logic [31:0] ang;
  cr_item_t    d_d;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign ang     = ATAN_TABLE[5'(STAGE)];

  // the same micro-rotation on all three vectors
  always_comb begin
    d_d       = data_i;
    d_d.roll  = cordic_step(data_i.roll, STAGE, ang);
    d_d.yaw   = cordic_step(data_i.yaw, STAGE, ang);
    d_d.pitch = cordic_step(data_i.pitch, STAGE, ang);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_o <= d_d;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import q2e_pkg::*;

  localparam longint Q30One = 64'sd1 << 30;

  // one angle result
  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    gimbal_e            gcase;
  } angles_t;

  // one directed request; typed rows carry a hand-read result
  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;
    angles_t            res;
  } quat_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] roll_angle_o, pitch_angle_o, yaw_angle_o;
  logic [1:0]         gimbal_case_o;

  angles_t     angles_q[$];
  logic [15:0] tol_model;
  int          idle_pct;
  int          stall_pct;
  int          errs;

  quaternion_to_euler_angles_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .quat_w_i     (quat_w_i),
    .quat_x_i     (quat_x_i),
    .quat_y_i     (quat_y_i),
    .quat_z_i     (quat_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .roll_angle_o (roll_angle_o),
    .pitch_angle_o(pitch_angle_o),
    .yaw_angle_o  (yaw_angle_o),
    .gimbal_case_o(gimbal_case_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // vectoring CORDIC, 16-bit binary angle out
  function automatic logic signed [15:0] vec_angle(longint vy, longint vx);
    longint      t;
    longint      dx;
    longint      dy;
    logic [31:0] acc;
    logic [31:0] rnd;
    acc = 32'h0;
    if (vx == 0 && vy == 0) return 16'sd0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; acc = 32'h4000_0000;
      end else begin
        vx = -vy; vy = t; acc = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CordicStagesDef; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; acc += ATAN_TABLE[i];
      end else begin
        vx -= dx; vy += dy; acc -= ATAN_TABLE[i];
      end
    end
    rnd = acc + 32'h0000_8000;
    return rnd[31:16];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // expected angles of one quaternion at the current tolerance
  function automatic angles_t quat_to_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz);
    angles_t r;
    longint  w, x, y, z, ww, xx, yy, zz, sn, dp, dm, num, tl;
    int      p;
    w = qw; x = qx; y = qy; z = qz;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    sn = 2 * (w * y - x * z);
    tl = tol_model;
    if (sn >= Q30One) p = 16384;
    else if (sn <= -Q30One) p = -16384;
    else begin
      p = vec_angle(sn, longint'(int_sqrt((64'd1 << 60) - longint'(sn * sn))));
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
    end
    r.pitch = p;
    dp = sn - Q30One;
    if (dp < 0) dp = -dp;
    dm = sn + Q30One;
    if (dm < 0) dm = -dm;
    if (dp < tl || dm < tl) begin
      num = 2 * (x * y - z * w);
      r.gcase = (dp < tl) ? GC_POS : GC_NEG;
      if (r.gcase == GC_NEG) num = -num;
      r.roll = vec_angle(num, ww - xx + yy - zz);
      r.yaw = 16'sd0;
    end else begin
      r.gcase = GC_NORMAL;
      r.roll = vec_angle(2 * (y * z + w * x), ww - xx - yy + zz);
      r.yaw = vec_angle(2 * (x * y + w * z), ww + xx - yy - zz);
    end
    return r;
  endfunction

  // drive one request, starting at a clock edge; returns at its acceptance edge or after an idle gap
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z,
                           bit typed, angles_t res);
    int gap;
    in_valid_i <= 1'b1;
    quat_w_i <= w; quat_x_i <= x; quat_y_i <= y; quat_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    angles_q.push_back(typed ? res : quat_to_angles(w, x, y, z));
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    tol_model = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random request, mostly near gimbal lock or of moderate size
  task automatic send_random();
    logic signed [15:0] w, x, y, z;
    int a;
    int kind;
    angles_t none;
    none = '{roll: 16'sd0, pitch: 16'sd0, yaw: 16'sd0, gcase: GC_NORMAL};
    kind = $urandom_range(99);
    if (kind < 35) begin
      a = 23170 + $urandom_range(0, 80) - 40;
      w = ($urandom_range(1)) ? a : -a;
      a = a + $urandom_range(0, 80) - 40;
      y = ($urandom_range(1)) ? a : -a;
      x = $urandom_range(0, 400) - 200;
      z = $urandom_range(0, 400) - 200;
      if ($urandom_range(1)) begin
        {w, x} = {x, w};
        {y, z} = {z, -y};
      end
    end else if (kind < 65) begin
      w = $urandom_range(0, 32767) - 16384;
      x = $urandom_range(0, 32767) - 16384;
      y = $urandom_range(0, 32767) - 16384;
      z = $urandom_range(0, 32767) - 16384;
    end else begin
      w = $urandom; x = $urandom; y = $urandom; z = $urandom;
    end
    send_quat(w, x, y, z, 1'b0, none);
  endtask

  // receive side: check accepted results, then set next ready
  always @(posedge clk_i) begin
    angles_t e;
    if (out_valid_o && out_ready_i) begin
      if (angles_q.size() == 0) begin
        $display("%0t: result with nothing expected: roll %0d pitch %0d yaw %0d case %0d",
                 $time, roll_angle_o, pitch_angle_o, yaw_angle_o, gimbal_case_o);
        errs++;
      end else begin
        e = angles_q.pop_front();
        if (roll_angle_o !== e.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle_o);
          errs++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_angle_o);
          errs++;
        end
        if (yaw_angle_o !== e.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_angle_o);
          errs++;
        end
        if (gimbal_case_o !== e.gcase) begin
          $display("%0t: case expected %0d actual %0d", $time, e.gcase, gimbal_case_o);
          errs++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("quaternion_to_euler_angles_unit: mismatch");
    $finish;
  end

  initial begin
    quat_row_t   rows[$];
    angles_t     none;
    angles_t     sat_up;
    logic [15:0] tols[8];
    int          idles[4];
    int          stalls[4];
    none = '{roll: 16'sd0, pitch: 16'sd0, yaw: 16'sd0, gcase: GC_NORMAL};
    sat_up = '{roll: 16'sd0, pitch: 16'sd16384, yaw: 16'sd0, gcase: GC_NORMAL};
    tols = '{16'd1, 16'd0, 16'd65535, 16'd0, 16'd1, 16'd32768, 16'd0, 16'd65535};
    tols[3] = $urandom;
    tols[6] = $urandom;
    idles = '{0, 48, 0, 33};
    stalls = '{0, 0, 48, 33};
    errs = 0;
    idle_pct = 0;
    stall_pct = 0;
    tol_model = TolReset;

    // directed rows: extremes, exact saturation of the pitch sine, gimbal lock
    rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, none},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, none},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, none},
      '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, none},
      '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, none},
      '{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0, none},
      '{-16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 1'b1, sat_up},
      '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b0, none},
      '{-16'sd32768, 16'sd0, -16'sd16384, 16'sd0, 1'b0, none},
      '{-16'sd32768, 16'sd0, 16'sd16384, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 1'b0, none},
      '{16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 1'b0, none},
      '{16'sd23170, 16'sd0, -16'sd23170, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd23170, 16'sd0, -16'sd23170, 1'b0, none},
      '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, none},
      '{16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 1'b0, none},
      '{16'sd100, 16'sd200, -16'sd300, 16'sd400, 1'b0, none},
      '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, none}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset tolerance
    foreach (rows[i]) send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                                rows[i].typed, rows[i].res);

    // random phases over tolerance, idling and stall settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_tol(tols[ph]);
      idle_pct = idles[ph % 4];
      stall_pct = stalls[ph % 4];
      for (int n = 0; n < 156; n++) begin
        if (ph == 3 && n == 78) drain();
        send_random();
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (errs == 0) $display("quaternion_to_euler_angles_unit: match");
    else $display("quaternion_to_euler_angles_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_front.sv
hdl/q2e_sqrt_cell.sv
hdl/q2e_cordic_cell.sv
hdl/quaternion_to_euler_angles_unit.sv
sim/tb.sv
